// ===== sv/shc_pkg.sv =====
// Package for the shell command tokenizer: character codes, result kinds,
// redirect tracking codes and the result entry type. No dependencies.

package shc_pkg;

   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_DQ    = 8'd34;
   localparam logic [7:0] CH_SQ    = 8'd39;
   localparam logic [7:0] CH_LT    = 8'd60;
   localparam logic [7:0] CH_GT    = 8'd62;
   localparam logic [7:0] CH_BAR   = 8'd124;

   // Kind of a result: token character or end of the current token
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Most results one character can cause
   localparam int unsigned MAX_RESULTS = 3;

   typedef enum logic [1:0] {
      PEND_NONE = 2'd0,
      PEND_LT   = 2'd1,
      PEND_GT   = 2'd2
   } pend_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       kind;
   } result_type;

endpackage

// ===== sv/shc_if.sv =====
// Channel interfaces for the shell command tokenizer: request (characters in)
// and response (token results out). Depends on nothing.

interface shc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       last_char;

   modport source (output valid, output in_char, output last_char, input ready);
   modport sink (input valid, input in_char, input last_char, output ready);
endinterface

interface shc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       kind;
   logic       run_last;

   modport source (output valid, output out_char, output kind, output run_last,
                   input ready);
   modport sink (input valid, input out_char, input kind, input run_last,
                 output ready);
endinterface

// ===== sv/shell_command_tokenizer.sv =====
// Shell command tokenizer top level: lexer state, result burst register.
// Depends on shc_pkg and the channel interfaces in shc_if.sv.
//
// Usage:
//   req_chan carries one command line character per request (in_char, and
//   last_char set on the final character of the line). rsp_chan returns the
//   token stream: token characters (kind 0) and token-end marks (kind 1,
//   out_char 0). run_last flags the final response caused by a request;
//   a request may cause zero to three responses.
//   The first response of a request appears in the cycle after the request
//   is taken. Throughput: one request per cycle while each request causes at
//   most one response and rsp_chan does not stall; a request that causes two
//   or three responses holds req_chan while the burst register drains, one
//   response a cycle.
//   A new request is taken in the same cycle that the last waiting response
//   is taken, so a steady stream is not interrupted.
//   Reset (synchronous, active high) clears the lexer state and drops any
//   responses still waiting. When rsp_chan stalls, the waiting response
//   holds and no new request is taken until it and the rest of its burst go.

module shell_command_tokenizer (
   input logic     clock,
   input logic     reset,
   shc_req_if.sink   req_chan,
   shc_rsp_if.source rsp_chan
);

   // Lexer state
   logic              token_open_ff, token_open_in;
   logic              in_quote_ff, in_quote_in;
   logic              quote_dq_ff, quote_dq_in;
   shc_pkg::pend_type pend_ff, pend_in;

   // Result burst
   shc_pkg::result_type burst_ff [shc_pkg::MAX_RESULTS];
   shc_pkg::result_type burst_in [shc_pkg::MAX_RESULTS];
   logic [1:0]          count_ff, count_in;
   logic [1:0]          rd_ff;

   logic       req_fire, rsp_fire;
   logic       burst_empty, burst_final;
   logic [1:0] rd_next;
   logic [7:0] ch;
   logic       last;
   logic       consumed;
   logic [7:0] pend_char;
   logic [7:0] quote_char;

   assign ch   = req_chan.in_char;
   assign last = req_chan.last_char;

   assign rd_next     = rd_ff + 2'd1;
   assign burst_empty = (rd_ff == count_ff);
   assign burst_final = (rd_next == count_ff);

   assign req_chan.ready = burst_empty || (burst_final && rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;

   assign rsp_chan.valid    = !burst_empty;
   assign rsp_chan.out_char = burst_ff[rd_ff].out_char;
   assign rsp_chan.kind     = burst_ff[rd_ff].kind;
   assign rsp_chan.run_last = burst_final;

   assign pend_char  = (pend_ff == shc_pkg::PEND_LT) ? shc_pkg::CH_LT : shc_pkg::CH_GT;
   assign quote_char = quote_dq_ff ? shc_pkg::CH_DQ : shc_pkg::CH_SQ;

   always_comb begin
      token_open_in = token_open_ff;
      in_quote_in   = in_quote_ff;
      quote_dq_in   = quote_dq_ff;
      pend_in       = pend_ff;
      count_in      = 2'd0;
      consumed      = 1'b0;
      for (int i = 0; i < shc_pkg::MAX_RESULTS; i++) begin
         burst_in[i] = '{out_char: 8'd0, kind: shc_pkg::KIND_END};
      end

      // Finish a pending < or > token: join a doubled char, then end it
      if (pend_ff != shc_pkg::PEND_NONE) begin
         pend_in = shc_pkg::PEND_NONE;
         if (ch == pend_char) begin
            burst_in[count_in] = '{out_char: ch, kind: shc_pkg::KIND_CHAR};
            count_in = count_in + 2'd1;
            consumed = 1'b1;
         end
         burst_in[count_in] = '{out_char: 8'd0, kind: shc_pkg::KIND_END};
         count_in = count_in + 2'd1;
         token_open_in = 1'b0;
      end

      if (!consumed) begin
         if (in_quote_ff) begin
            burst_in[count_in] = '{out_char: ch, kind: shc_pkg::KIND_CHAR};
            count_in = count_in + 2'd1;
            if (ch == quote_char) begin
               in_quote_in = 1'b0;
            end
         end else if (ch == shc_pkg::CH_SPACE) begin
            if (token_open_in) begin
               burst_in[count_in] = '{out_char: 8'd0, kind: shc_pkg::KIND_END};
               count_in = count_in + 2'd1;
               token_open_in = 1'b0;
            end
         end else if (ch == shc_pkg::CH_DQ || ch == shc_pkg::CH_SQ) begin
            burst_in[count_in] = '{out_char: ch, kind: shc_pkg::KIND_CHAR};
            count_in = count_in + 2'd1;
            token_open_in = 1'b1;
            in_quote_in   = 1'b1;
            quote_dq_in   = (ch == shc_pkg::CH_DQ);
         end else if (ch == shc_pkg::CH_LT || ch == shc_pkg::CH_GT ||
                      ch == shc_pkg::CH_BAR) begin
            if (token_open_in) begin
               burst_in[count_in] = '{out_char: 8'd0, kind: shc_pkg::KIND_END};
               count_in = count_in + 2'd1;
            end
            burst_in[count_in] = '{out_char: ch, kind: shc_pkg::KIND_CHAR};
            count_in = count_in + 2'd1;
            token_open_in = 1'b1;
            if (ch == shc_pkg::CH_BAR || last) begin
               // pipe never doubles; a redirect at end of line closes now
               burst_in[count_in] = '{out_char: 8'd0, kind: shc_pkg::KIND_END};
               count_in = count_in + 2'd1;
               token_open_in = 1'b0;
            end else begin
               pend_in = (ch == shc_pkg::CH_LT) ? shc_pkg::PEND_LT : shc_pkg::PEND_GT;
            end
         end else begin
            burst_in[count_in] = '{out_char: ch, kind: shc_pkg::KIND_CHAR};
            count_in = count_in + 2'd1;
            token_open_in = 1'b1;
         end
      end

      // End of line: close the open token and return to the idle state
      if (last) begin
         if (token_open_in) begin
            burst_in[count_in] = '{out_char: 8'd0, kind: shc_pkg::KIND_END};
            count_in = count_in + 2'd1;
         end
         token_open_in = 1'b0;
         in_quote_in   = 1'b0;
         quote_dq_in   = 1'b0;
         pend_in       = shc_pkg::PEND_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_open_ff <= 1'b0;
         in_quote_ff   <= 1'b0;
         quote_dq_ff   <= 1'b0;
         pend_ff       <= shc_pkg::PEND_NONE;
         count_ff      <= 2'd0;
         rd_ff         <= 2'd0;
      end else if (req_fire) begin
         token_open_ff <= token_open_in;
         in_quote_ff   <= in_quote_in;
         quote_dq_ff   <= quote_dq_in;
         pend_ff       <= pend_in;
         count_ff      <= count_in;
         rd_ff         <= 2'd0;
      end else if (rsp_fire) begin
         rd_ff <= rd_next;
      end
   end

   // Burst payload: load on each request
   always_ff @(posedge clock) begin
      if (req_fire) begin
         burst_ff <= burst_in;
      end
   end

endmodule

// ===== sv/shc_checker.sv =====
// Port-level checks for the shell command tokenizer, bound to the top level.
// Depends on shc_pkg and the top level's channel ports.

module shc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_kind,
   input logic       rsp_run_last
);

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) &&
                                  $stable(rsp_kind) && $stable(rsp_run_last))
      else $error("stalled response changed");

   // Reset drops any waiting responses
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Token-end marks carry a zero character
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == shc_pkg::KIND_END |-> rsp_out_char == 8'd0)
      else $error("token end with non-zero character");

   // A request is taken only once the previous burst is gone or ending now
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_valid |-> rsp_ready && rsp_run_last)
      else $error("request taken over an undelivered burst");

endmodule

bind shell_command_tokenizer shc_checker u_shc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_char (rsp_chan.out_char),
   .rsp_kind     (rsp_chan.kind),
   .rsp_run_last (rsp_chan.run_last)
);
